/* sv/brs_pkg.sv */
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types, constants and a helper function for the allocation bitmap
// range-set and run-check block.
// ----------------------------------------------------------------------------
`default_nettype none

package brs_pkg;

  // Map geometry.
  localparam int WORD_BITS  = 64;
  localparam int MAP_WORDS  = 64;
  localparam int ADDR_W     = $clog2(MAP_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int CNT_W      = BIT_W + 1;          // 0..WORD_BITS
  localparam int START_W    = 12;
  localparam int LEN_W      = 13;
  localparam int TOTAL_BITS = MAP_WORDS * WORD_BITS;

  // Operation codes.
  localparam logic OP_SET   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // One request.
  typedef struct packed {
    logic               op;
    logic [START_W-1:0] start_bit;
    logic [LEN_W-1:0]   length;
  } req_t;

  // One result.
  typedef struct packed {
    logic [LEN_W-1:0] run_length;
    logic             range_clipped;
  } rsp_t;

  // Result of processing one map word.
  typedef struct packed {
    logic [WORD_BITS-1:0] wdata;   // word with the span ORed in
    logic [CNT_W-1:0]     span;    // bits of the range inside this word
    logic [CNT_W-1:0]     ones;    // run of set bits from the start position
    logic                 short_run; // run stops inside this word
  } step_t;

  // Number of consecutive ones starting at bit 0.
  function automatic logic [CNT_W-1:0] trailing_ones(input logic [WORD_BITS-1:0] v);
    logic [CNT_W-1:0] cnt;
    cnt = CNT_W'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) begin
        cnt = CNT_W'(i);
      end
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

/* sv/brs_ram.sv */
// ----------------------------------------------------------------------------
// brs_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/brs_word_alu.sv */
// ----------------------------------------------------------------------------
// brs_word_alu
// Per-word datapath: span of the range in the current word, the OR mask for a
// set, and the trailing-ones count for a check.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_word_alu
  import brs_pkg::*;
(
  input  wire logic [WORD_BITS-1:0] data,
  input  wire logic [BIT_W-1:0]     bit_pos,
  input  wire logic [LEN_W-1:0]     remain,
  output      step_t                step
);

  logic [CNT_W-1:0]     room;
  logic [CNT_W-1:0]     span;
  logic [WORD_BITS-1:0] low_mask;
  logic [WORD_BITS-1:0] shifted;

  // Bits of the range that fall in this word.
  always_comb begin
    room = CNT_W'(WORD_BITS) - {1'b0, bit_pos};
    if (remain < LEN_W'(room)) begin
      span = remain[CNT_W-1:0];
    end else begin
      span = room;
    end
  end

  // Mask of span ones at bit 0; it is shifted to the start position when ORed in.
  always_comb begin
    if (span[CNT_W-1]) begin
      low_mask = '1;
    end else begin
      low_mask = (WORD_BITS'(1) << span[BIT_W-1:0]) - WORD_BITS'(1);
    end
  end

  assign shifted = data >> bit_pos;

  // Pack the step result.
  always_comb begin
    step.wdata     = data | (low_mask << bit_pos);
    step.span      = span;
    step.ones      = trailing_ones(shifted);
    step.short_run = (step.ones < span);
  end

endmodule

`default_nettype wire

/* sv/bitmap_range_set_run_check.sv */
// ----------------------------------------------------------------------------
// bitmap_range_set_run_check
// Allocation bitmap with range-set and run-length-check requests.
// ----------------------------------------------------------------------------
// The map holds 4096 bits as 64 words of 64 bits in a RAM with a registered
// read. A request is taken only while the block is idle. A set ORs ones into
// [start_bit, start_bit + length); a check reports the run of set bits from
// start_bit, capped at length. Ranges past the map end are clipped and flagged
// with range_clipped. Each map word the range touches takes a read state,
// then a modify and write-back state; a finish state then loads the result
// once the result register is free, and the block then returns to idle to
// take the next request. A zero length request goes straight to the finish
// state. A check stops at the first word where the run ends. The map reads
// as zero after reset: a valid bit per word marks the words written since,
// so no clearing pass is needed and requests are taken right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_range_set_run_check
  import brs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output      logic req_stall,
  input  wire req_t req,
  output      logic rsp_valid,
  input  wire logic rsp_stall,
  output      rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_PROC = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic                 op;
  logic [LEN_W-1:0]     lo;
  logic [LEN_W-1:0]     hi;
  logic [LEN_W-1:0]     run;
  logic                 clipped;
  logic [MAP_WORDS-1:0] word_valid;

  logic                 req_take;
  logic [LEN_W:0]       req_end;
  logic [ADDR_W-1:0]    word_idx;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] word_data;
  logic [LEN_W-1:0]     lo_adv;
  logic                 ram_we;
  logic                 rsp_free;
  step_t                step;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign req_end   = (LEN_W+1)'(req.start_bit) + (LEN_W+1)'(req.length);
  assign word_idx  = lo[BIT_W+ADDR_W-1:BIT_W];
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Map storage.
  brs_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(word_idx),
    .wdata(step.wdata),
    .re   (state == S_READ),
    .raddr(word_idx),
    .rdata(ram_rdata)
  );

  // A word never written since reset reads as zero.
  assign word_data = word_valid[word_idx] ? ram_rdata : '0;

  brs_word_alu u_alu (
    .data   (word_data),
    .bit_pos(lo[BIT_W-1:0]),
    .remain (hi - lo),
    .step   (step)
  );

  assign lo_adv = lo + LEN_W'(step.span);
  assign ram_we = (state == S_PROC) && (op == OP_SET);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_take) begin
          state_next = (req.length != '0) ? S_READ : S_FIN;
        end
      end
      S_READ: begin
        state_next = S_PROC;
      end
      S_PROC: begin
        if ((op == OP_CHECK && step.short_run) || lo_adv >= hi) begin
          state_next = S_FIN;
        end else begin
          state_next = S_READ;
        end
      end
      S_FIN: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request registers and the walk position.
  always_ff @(posedge clk) begin
    if (req_take) begin
      op      <= req.op;
      lo      <= LEN_W'(req.start_bit);
      hi      <= (req_end > (LEN_W+1)'(TOTAL_BITS)) ? LEN_W'(TOTAL_BITS) : LEN_W'(req_end);
      clipped <= (req_end > (LEN_W+1)'(TOTAL_BITS));
      run     <= '0;
    end else if (state == S_PROC) begin
      lo <= lo_adv;
      if (step.short_run) begin
        run <= run + LEN_W'(step.ones);
      end else begin
        run <= run + LEN_W'(step.span);
      end
    end
  end

  // Written-word flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (ram_we) begin
      word_valid[word_idx] <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_FIN && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && rsp_free) begin
      rsp.run_length    <= (op == OP_CHECK) ? run : '0;
      rsp.range_clipped <= clipped;
    end
  end

  // The walk stays inside the clipped range.
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROC) |-> (lo < hi))
    else $error("walk position outside the range");

  // The range end never passes the map end.
  a_hi_bounded: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (hi <= LEN_W'(TOTAL_BITS)))
    else $error("range end beyond the map");

  // A new result appears only after the finish state.
  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_FIN))
    else $error("result raised outside the finish state");

endmodule

`default_nettype wire

/* verif/bitmap_run_checker.sv */
// ----------------------------------------------------------------------------
// bitmap_run_checker
// Scoreboard for the allocation bitmap range-set and run-check block.
// ----------------------------------------------------------------------------
// Watches the request and result channels. Each accepted request is applied
// to a flat shadow copy of the 4096-bit map, one bit at a time, and the result
// that it should produce is queued. Each accepted result is compared field by
// field with the oldest queued result. Mismatches and unexpected results are
// counted; the first ten are printed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_run_checker
  import brs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   errors,
  output int   pending,
  output int   compared,
  output int   nonzero_runs
);

  // Shadow map: bit n of the map is bit n of this vector.
  logic [TOTAL_BITS-1:0] map_bits;
  rsp_t                  expected_results[$];

  // Apply one request to the shadow map and return the result it yields.
  function automatic rsp_t predict_bitmap_request(input req_t r);
    int unsigned first;
    int unsigned stop;
    logic        counting;
    rsp_t        res;
    first    = r.start_bit;
    stop     = first + r.length;
    counting = 1'b1;
    res      = '0;
    res.range_clipped = (first >= TOTAL_BITS) || (stop > TOTAL_BITS);
    if (stop > TOTAL_BITS) begin
      stop = TOTAL_BITS;
    end
    for (int unsigned idx = first; idx < stop; idx++) begin
      if (r.op == OP_SET) begin
        map_bits[idx] = 1'b1;
      end else if (counting && map_bits[idx]) begin
        res.run_length = res.run_length + 1'b1;
      end else begin
        counting = 1'b0;
      end
    end
    return res;
  endfunction

  // Compare results first: a result never belongs to a request taken at the
  // same edge.
  always @(posedge clk) begin : monitor
    rsp_t want;
    if (rst) begin
      map_bits = '0;
      expected_results.delete();
      errors       = 0;
      pending      = 0;
      compared     = 0;
      nonzero_runs = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t ERROR: unexpected result run_length=%0d range_clipped=%0b",
                     $time, rsp.run_length, rsp.range_clipped);
          end
        end else begin
          want = expected_results.pop_front();
          compared++;
          if (rsp.run_length !== want.run_length ||
              rsp.range_clipped !== want.range_clipped) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t ERROR: run_length exp %0d got %0d, range_clipped exp %0b got %0b",
                       $time, want.run_length, rsp.run_length,
                       want.range_clipped, rsp.range_clipped);
            end
          end
        end
      end

      // Predict the result of a request accepted at this edge.
      if (req_valid && !req_stall) begin
        want = predict_bitmap_request(req);
        if (req.op == OP_CHECK && want.run_length != '0) begin
          nonzero_runs++;
        end
        expected_results.push_back(want);
      end
      pending = expected_results.size();
    end
  end

endmodule

/* verif/tb_bitmap_range_set_run_check.sv */
// ----------------------------------------------------------------------------
// tb_bitmap_range_set_run_check
// Testbench for the allocation bitmap range-set and run-check block.
// ----------------------------------------------------------------------------
// Drives a directed set of requests (empty ranges, whole and partial words,
// runs ending on word boundaries, ranges clipped at the map end), then about
// 400 random requests in three idle profiles: sender mostly busy with a slow
// receiver, the reverse, and no idling at all. Random checks often start on
// recently set ranges so that runs of set bits are actually found. A separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitmap_range_set_run_check;
  import brs_pkg::*;

  // Longest request walks all 64 words of the map.
  localparam int DRAIN_CYCLES = 140;
  localparam int RANDOM_PER_PHASE = 134;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int errors;
  int pending;
  int compared;
  int nonzero_runs;
  int num_sets    = 0;
  int num_checks  = 0;
  int num_clipped = 0;

  // Start bits of recent set requests; checks aim at these.
  logic [START_W-1:0] set_starts[$];

  initial begin
    forever #1 clk = ~clk;
  end

  bitmap_range_set_run_check i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  bitmap_run_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .errors       (errors),
    .pending      (pending),
    .compared     (compared),
    .nonzero_runs (nonzero_runs)
  );

  // Receiver back-pressure.
  always @(posedge clk) begin
    rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Present one request, with random idle cycles ahead of it, and hold it
  // until the transfer happens. Valid stays high for back-to-back requests.
  task automatic send_request(input logic op, input int unsigned start,
                              input int unsigned len);
    req_t item;
    item.op        = op;
    item.start_bit = START_W'(start);
    item.length    = LEN_W'(len);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) begin
      @(posedge clk);
    end
    if (op == OP_SET) begin
      num_sets++;
    end else begin
      num_checks++;
    end
    if (start + len > TOTAL_BITS) begin
      num_clipped++;
    end
  endtask

  // Mostly short sets spread over the map, with checks aimed at them.
  task automatic send_random_request();
    logic        op;
    int unsigned start;
    int unsigned len;
    int unsigned pick;
    op = ($urandom_range(99) < 40) ? OP_SET : OP_CHECK;
    if (op == OP_SET) begin
      pick = $urandom_range(19);
      if (pick == 0) begin
        // Long set near the top: clips without flooding the map.
        start = $urandom_range(3840, 4095);
        len   = $urandom_range(0, 8191);
      end else begin
        start = $urandom_range(0, 4095);
        len   = (pick == 1) ? $urandom_range(25, 200) : $urandom_range(0, 24);
        set_starts.push_back(START_W'(start));
        if (set_starts.size() > 16) begin
          void'(set_starts.pop_front());
        end
      end
    end else begin
      if (set_starts.size() != 0 && $urandom_range(3) != 0) begin
        start = (set_starts[$urandom_range(set_starts.size() - 1)] +
                 $urandom_range(0, 8)) % TOTAL_BITS;
      end else begin
        start = $urandom_range(0, 4095);
      end
      len = ($urandom_range(2) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 64);
    end
    send_request(op, start, len);
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 67;

    // Empty map and zero lengths.
    send_request(OP_CHECK, 0, 0);
    send_request(OP_CHECK, 0, 4096);
    send_request(OP_SET, 0, 0);
    // One whole word; the run then ends on a word boundary.
    send_request(OP_SET, 0, 64);
    send_request(OP_CHECK, 0, 4096);
    send_request(OP_CHECK, 0, 64);
    // Last bit of the map, and ranges clipped at the map end.
    send_request(OP_SET, 4095, 1);
    send_request(OP_CHECK, 4095, 1);
    send_request(OP_CHECK, 4095, 2);
    send_request(OP_SET, 4000, 8191);
    send_request(OP_CHECK, 3990, 8191);
    send_request(OP_CHECK, 4000, 8191);
    // Partial word that ends on a boundary, then the gap below it filled.
    send_request(OP_SET, 100, 28);
    send_request(OP_CHECK, 100, 28);
    send_request(OP_CHECK, 96, 40);
    send_request(OP_SET, 64, 36);
    send_request(OP_CHECK, 0, 4096);
    send_request(OP_CHECK, 10, 8191);
    // Partial first word, whole middle words, partial last word.
    send_request(OP_SET, 130, 200);
    send_request(OP_CHECK, 130, 199);
    send_request(OP_CHECK, 130, 300);
    send_request(OP_CHECK, 329, 1);
    send_request(OP_CHECK, 330, 5);
    send_request(OP_SET, 2048, 0);
    send_request(OP_CHECK, 2048, 0);

    // Random requests under three idle profiles.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) send_random_request();
    end

    // Drain: wait for every result, then give stray results time to show up.
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d set and %0d check requests, %0d of them clipped at the map end.",
             num_sets, num_checks, num_clipped);
    $display("Compared %0d results, %0d checks found a nonzero run, %0d mismatches.",
             compared, nonzero_runs, errors);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("Timeout with %0d results still outstanding.", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
